### hdl/circle_rect_collision_normal_defines.svh
// assertion macros for the circle against rectangle collision block
`ifndef CIRCLE_RECT_COLLISION_NORMAL_DEFINES_SVH
`define CIRCLE_RECT_COLLISION_NORMAL_DEFINES_SVH
`ifndef SYNTH
`define CRCN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define CRCN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define CRCN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CRCN_ASSERT(lbl, prop, msg)
`define CRCN_ASSERT_IMP(lbl, ante, cons, msg)
`define CRCN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/crcn_pkg.sv
// shared types and constants of the collision block
`default_nettype none
package crcn_pkg;
	typedef logic [2:0] edge_t;
	localparam edge_t EDGE_TOP    = 3'd0;
	localparam edge_t EDGE_RIGHT  = 3'd1;
	localparam edge_t EDGE_BOTTOM = 3'd2;
	localparam edge_t EDGE_LEFT   = 3'd3;
	localparam edge_t EDGE_NONE   = 3'd4;
	// the rounding search works on twice the scaled quotient, squared
	localparam int ROUND_SCALE_BITS = 2;
endpackage
`default_nettype wire

### hdl/crcn_norm_root.sv
// pipelined bit-serial square root quotient for one normal component
`default_nettype none
module crcn_norm_root #(
	parameter int COORD_BITS = 24,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  wire                                     clk,
	input  wire                                     en,
	input  wire  [2*COORD_BITS-1:0]                 sq,
	input  wire  [2*COORD_BITS:0]                   s,
	input  wire                                     neg,
	output logic signed [NORMAL_FRAC_BITS+1:0]      comp
);
	localparam int CW  = COORD_BITS;
	localparam int F   = NORMAL_FRAC_BITS;
	localparam int NST = F + 2;
	localparam int MW  = 2 * CW + 2 * F + 4;

	logic [MW-1:0]   rm_s  [1:NST];
	logic [MW-1:0]   p_s   [1:NST];
	logic [2*CW:0]   sum_s [1:NST];
	logic [NST-1:0]  y_s   [1:NST];
	logic            neg_s [1:NST];
	logic [NST-1:0]  lo;

	for (genvar i = 0; i < NST; i++) begin : g_stage
		localparam int K = NST - 1 - i;
		logic [MW-1:0]  rm_i;
		logic [MW-1:0]  p_i;
		logic [MW-1:0]  inc;
		logic [2*CW:0]  s_i;
		logic [NST-1:0] y_i;
		logic           neg_i;
		logic           ok;
		if (i == 0) begin : g_first
			assign rm_i  = MW'(sq) << (2 * F + crcn_pkg::ROUND_SCALE_BITS);
			assign p_i   = '0;
			assign s_i   = s;
			assign y_i   = '0;
			assign neg_i = neg;
		end else begin : g_next
			assign rm_i  = rm_s[i];
			assign p_i   = p_s[i];
			assign s_i   = sum_s[i];
			assign y_i   = y_s[i];
			assign neg_i = neg_s[i];
		end
		// (y + 2^k)^2 s - y^2 s, with p = y s
		assign inc = (p_i << (K + 1)) + (MW'(s_i) << (2 * K));
		assign ok  = inc <= rm_i;
		always_ff @(posedge clk) begin
			if (en) begin
				rm_s[i+1]  <= ok ? rm_i - inc : rm_i;
				p_s[i+1]   <= ok ? p_i + (MW'(s_i) << K) : p_i;
				y_s[i+1]   <= ok ? (y_i | (NST'(1) << K)) : y_i;
				sum_s[i+1] <= s_i;
				neg_s[i+1] <= neg_i;
			end
		end
	end

	assign lo   = (y_s[NST] + NST'(1)) >> 1;
	assign comp = neg_s[NST] ? -$signed(lo) : $signed(lo);
endmodule
`default_nettype wire

### hdl/circle_rect_collision_normal.sv
// top level: circle against rectangle edge test with reflected unit normal
// Input channel s_*: one circle and rectangle pair per transfer, packed in
// s_tdata. Output channel m_*: one result per pair, in order: hit flag and
// the reflected velocity scaled to unit length in signed Q1.14.
// The path from input transfer to m_tvalid runs through six arithmetic
// stages, one root stage per result bit of the normal (NORMAL_FRAC_BITS + 2)
// and the output register.
// Throughput is one pair per cycle unless m_tready stalls the output; each stage holds one pair.
// The whole pipeline advances together. When the output register is full
// and m_tready is low, every stage holds and s_tready drops in the same
// cycle, so nothing is lost or repeated.
// Reset empties the pipeline: no result is presented until new pairs arrive.
// No state is carried between pairs.
`default_nettype none
`include "circle_rect_collision_normal_defines.svh"
module circle_rect_collision_normal #(
	parameter int COORD_BITS = 24,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  wire clk,
	input  wire arst_n,
	input  wire s_tvalid,
	output logic s_tready,
	// circle_x, circle_y, circle_vx, circle_vy, circle_radius, rect_x, rect_y,
	// rect_width, rect_height, zero fill
	input  wire [((9*COORD_BITS-3+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  wire m_tready,
	// hit, normal_x, normal_y, zero fill
	output logic [((2*NORMAL_FRAC_BITS+5+7)/8)*8-1:0] m_tdata
);
	localparam int CW  = COORD_BITS;
	localparam int UW  = CW - 1;
	localparam int DW  = CW + 2;
	localparam int SQW = 2 * UW;
	localparam int F   = NORMAL_FRAC_BITS;
	localparam int NW  = F + 2;
	localparam int NST = F + 2;
	localparam int NV  = 6 + NST;
	localparam int OW  = ((2*NORMAL_FRAC_BITS+5+7)/8)*8;
	localparam logic signed [NW-1:0] UNIT = NW'(2**F);

	function automatic logic [DW-1:0] mag_f(input logic signed [DW-1:0] d);
		mag_f = d[DW-1] ? DW'(-d) : DW'(d);
	endfunction

	logic en;
	logic [NV-1:0] vld_q;

	logic signed [CW-1:0] cx, cy, vx, vy, rx, ry;
	logic [UW-1:0] r, w, h;

	assign cx = s_tdata[CW-1:0];
	assign cy = s_tdata[2*CW-1:CW];
	assign vx = s_tdata[3*CW-1:2*CW];
	assign vy = s_tdata[4*CW-1:3*CW];
	assign r  = s_tdata[4*CW+UW-1:4*CW];
	assign rx = s_tdata[5*CW+UW-1:4*CW+UW];
	assign ry = s_tdata[6*CW+UW-1:5*CW+UW];
	assign w  = s_tdata[6*CW+2*UW-1:6*CW+UW];
	assign h  = s_tdata[6*CW+3*UW-1:6*CW+2*UW];

	logic out_vld_q;
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NV-2:0], s_tvalid};
		end
	end

	// stage 1: offsets from the rectangle sides
	logic signed [DW-1:0] dxl_s1, dxr_s1, dyt_s1, dyb_s1;
	logic [CW-1:0] avx_s1, avy_s1;
	logic vxp_s1, vxn_s1, vyp_s1, vyn_s1, wz_s1;
	logic [UW-1:0] r_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dxl_s1 <= DW'(cx) - DW'(rx);
			dxr_s1 <= DW'(cx) - DW'(rx) - $signed(DW'(w));
			dyt_s1 <= DW'(cy) - DW'(ry);
			dyb_s1 <= DW'(cy) - DW'(ry) + $signed(DW'(h));
			avx_s1 <= vx[CW-1] ? CW'(-vx) : CW'(vx);
			avy_s1 <= vy[CW-1] ? CW'(-vy) : CW'(vy);
			vxn_s1 <= vx[CW-1];
			vxp_s1 <= !vx[CW-1] && (vx != '0);
			vyn_s1 <= vy[CW-1];
			vyp_s1 <= !vy[CW-1] && (vy != '0);
			wz_s1  <= (w == '0);
			r_s1   <= r;
		end
	end

	// stage 2: distances to the closest points, in range against the radius
	logic signed [DW-1:0] dxc, dyc;
	logic [DW-1:0] mxc_s2, mxr_s2, mxl_s2, myc_s2, myt_s2, myb_s2;
	logic ltxc_s2, ltxr_s2, ltxl_s2, ltyc_s2, ltyt_s2, ltyb_s2;
	logic xrle_s2, xlle_s2, ytle_s2, yble_s2;
	logic [CW-1:0] avx_s2, avy_s2;
	logic vxp_s2, vxn_s2, vyp_s2, vyn_s2, wz_s2;
	logic [UW-1:0] r_s2;

	assign dxc = dxl_s1[DW-1] ? dxl_s1 : ((dxr_s1 > 0) ? dxr_s1 : '0);
	assign dyc = dyb_s1[DW-1] ? dyb_s1 : ((dyt_s1 > 0) ? dyt_s1 : '0);

	always_ff @(posedge clk) begin
		if (en) begin
			mxc_s2  <= mag_f(dxc);
			mxr_s2  <= mag_f(dxr_s1);
			mxl_s2  <= mag_f(dxl_s1);
			myc_s2  <= mag_f(dyc);
			myt_s2  <= mag_f(dyt_s1);
			myb_s2  <= mag_f(dyb_s1);
			ltxc_s2 <= mag_f(dxc) < DW'(r_s1);
			ltxr_s2 <= mag_f(dxr_s1) < DW'(r_s1);
			ltxl_s2 <= mag_f(dxl_s1) < DW'(r_s1);
			ltyc_s2 <= mag_f(dyc) < DW'(r_s1);
			ltyt_s2 <= mag_f(dyt_s1) < DW'(r_s1);
			ltyb_s2 <= mag_f(dyb_s1) < DW'(r_s1);
			xrle_s2 <= dxr_s1 <= 0;
			xlle_s2 <= dxl_s1 <= 0;
			ytle_s2 <= dyt_s1 <= 0;
			yble_s2 <= dyb_s1 <= 0;
			avx_s2  <= avx_s1;
			avy_s2  <= avy_s1;
			vxp_s2  <= vxp_s1;
			vxn_s2  <= vxn_s1;
			vyp_s2  <= vyp_s1;
			vyn_s2  <= vyn_s1;
			wz_s2   <= wz_s1;
			r_s2    <= r_s1;
		end
	end

	// stage 3: squares, only meaningful where the distance is below the radius
	logic [SQW-1:0] sxc_s3, sxr_s3, sxl_s3, syc_s3, syt_s3, syb_s3, r2_s3;
	logic ltxc_s3, ltxr_s3, ltxl_s3, ltyc_s3, ltyt_s3, ltyb_s3;
	logic xrle_s3, xlle_s3, ytle_s3, yble_s3;
	logic [CW-1:0] avx_s3, avy_s3;
	logic vxp_s3, vxn_s3, vyp_s3, vyn_s3, wz_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sxc_s3  <= SQW'(mxc_s2[UW-1:0]) * SQW'(mxc_s2[UW-1:0]);
			sxr_s3  <= SQW'(mxr_s2[UW-1:0]) * SQW'(mxr_s2[UW-1:0]);
			sxl_s3  <= SQW'(mxl_s2[UW-1:0]) * SQW'(mxl_s2[UW-1:0]);
			syc_s3  <= SQW'(myc_s2[UW-1:0]) * SQW'(myc_s2[UW-1:0]);
			syt_s3  <= SQW'(myt_s2[UW-1:0]) * SQW'(myt_s2[UW-1:0]);
			syb_s3  <= SQW'(myb_s2[UW-1:0]) * SQW'(myb_s2[UW-1:0]);
			r2_s3   <= SQW'(r_s2) * SQW'(r_s2);
			ltxc_s3 <= ltxc_s2;
			ltxr_s3 <= ltxr_s2;
			ltxl_s3 <= ltxl_s2;
			ltyc_s3 <= ltyc_s2;
			ltyt_s3 <= ltyt_s2;
			ltyb_s3 <= ltyb_s2;
			xrle_s3 <= xrle_s2;
			xlle_s3 <= xlle_s2;
			ytle_s3 <= ytle_s2;
			yble_s3 <= yble_s2;
			avx_s3  <= avx_s2;
			avy_s3  <= avy_s2;
			vxp_s3  <= vxp_s2;
			vxn_s3  <= vxn_s2;
			vyp_s3  <= vyp_s2;
			vyn_s3  <= vyn_s2;
			wz_s3   <= wz_s2;
		end
	end

	// stage 4: first edge hit, reflected vector
	logic hit_t, hit_r, hit_b, hit_l;
	crcn_pkg::edge_t sel;
	logic vert, le, mv;
	logic [CW-1:0] ax, ay;
	logic nxn, nyn;
	logic [CW-1:0] ax_s4, ay_s4;
	logic nxn_s4, nyn_s4, hit_s4;

	assign hit_t = ltxc_s3 && ltyt_s3 &&
		((SQW+1)'(sxc_s3) + (SQW+1)'(syt_s3) < (SQW+1)'(r2_s3));
	assign hit_r = ltxr_s3 && ltyc_s3 &&
		((SQW+1)'(sxr_s3) + (SQW+1)'(syc_s3) < (SQW+1)'(r2_s3));
	assign hit_b = ltxc_s3 && ltyb_s3 &&
		((SQW+1)'(sxc_s3) + (SQW+1)'(syb_s3) < (SQW+1)'(r2_s3));
	assign hit_l = ltxl_s3 && ltyc_s3 &&
		((SQW+1)'(sxl_s3) + (SQW+1)'(syc_s3) < (SQW+1)'(r2_s3));

	always_comb begin
		if (hit_t) begin
			sel = crcn_pkg::EDGE_TOP;
		end else if (hit_r) begin
			sel = crcn_pkg::EDGE_RIGHT;
		end else if (hit_b) begin
			sel = crcn_pkg::EDGE_BOTTOM;
		end else if (hit_l) begin
			sel = crcn_pkg::EDGE_LEFT;
		end else begin
			sel = crcn_pkg::EDGE_NONE;
		end
	end

	always_comb begin
		vert = 1'b0;
		le   = 1'b0;
		mv   = 1'b0;
		case (sel)
			crcn_pkg::EDGE_TOP: begin
				vert = wz_s3;
				le   = wz_s3 ? xlle_s3 : ytle_s3;
				mv   = 1'b1;
			end
			crcn_pkg::EDGE_RIGHT: begin
				vert = 1'b1;
				le   = xrle_s3;
				mv   = 1'b1;
			end
			crcn_pkg::EDGE_BOTTOM: begin
				vert = wz_s3;
				le   = wz_s3 ? xlle_s3 : yble_s3;
				mv   = 1'b1;
			end
			crcn_pkg::EDGE_LEFT: begin
				vert = 1'b1;
				le   = xlle_s3;
				mv   = 1'b1;
			end
			default: begin
				vert = 1'b0;
				le   = 1'b0;
				mv   = 1'b0;
			end
		endcase
	end

	always_comb begin
		ax  = '0;
		ay  = '0;
		nxn = 1'b0;
		nyn = 1'b0;
		if (mv && vert && ((le && vxp_s3) || (!le && vxn_s3))) begin
			ax  = avx_s3;
			ay  = avy_s3;
			nxn = vxp_s3;
			nyn = vyn_s3;
		end else if (mv && !vert && ((le && vyp_s3) || (!le && vyn_s3))) begin
			ax  = avx_s3;
			ay  = avy_s3;
			nxn = vxn_s3;
			nyn = vyp_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s4  <= ax;
			ay_s4  <= ay;
			nxn_s4 <= nxn;
			nyn_s4 <= nyn;
			hit_s4 <= (sel != crcn_pkg::EDGE_NONE);
		end
	end

	// stage 5 and 6: squared length of the vector
	logic [2*CW-1:0] sx_s5, sy_s5, sx_s6, sy_s6;
	logic [2*CW:0] len2_s6;
	logic nxn_s5, nyn_s5, nxn_s6, nyn_s6;
	logic [NST+1:0] hitd_q;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s5   <= (2*CW)'(ax_s4) * (2*CW)'(ax_s4);
			sy_s5   <= (2*CW)'(ay_s4) * (2*CW)'(ay_s4);
			nxn_s5  <= nxn_s4;
			nyn_s5  <= nyn_s4;
			sx_s6   <= sx_s5;
			sy_s6   <= sy_s5;
			len2_s6 <= (2*CW+1)'(sx_s5) + (2*CW+1)'(sy_s5);
			nxn_s6  <= nxn_s5;
			nyn_s6  <= nyn_s5;
			hitd_q  <= {hitd_q[NST:0], hit_s4};
		end
	end

	logic signed [NW-1:0] nx, ny;

	crcn_norm_root #(
		.COORD_BITS(COORD_BITS),
		.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
	) u_root_x (
		.clk(clk),
		.en(en),
		.sq(sx_s6),
		.s(len2_s6),
		.neg(nxn_s6),
		.comp(nx)
	);

	crcn_norm_root #(
		.COORD_BITS(COORD_BITS),
		.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
	) u_root_y (
		.clk(clk),
		.en(en),
		.sq(sy_s6),
		.s(len2_s6),
		.neg(nyn_s6),
		.comp(ny)
	);

	// output register
	logic hit_q;
	logic signed [NW-1:0] nx_q, ny_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_q[NV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= hitd_q[NST+1];
			nx_q  <= nx;
			ny_q  <= ny;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OW'({ny_q, nx_q, hit_q});

	`CRCN_ASSERT_IMP(a_nohit_zero, out_vld_q && !hit_q, nx_q == '0 && ny_q == '0, "normal without hit")
	`CRCN_ASSERT_IMP(a_unit_range, out_vld_q, nx_q <= UNIT && nx_q >= -UNIT && ny_q <= UNIT && ny_q >= -UNIT, "normal out of range")
	`CRCN_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_q) && $stable(hit_q), "pipeline moved while stalled")
	`CRCN_ASSERT(a_ready_stall, s_tready == (!out_vld_q || m_tready), "ready does not follow output stall")
endmodule
`default_nettype wire
